@@ rtl/vtv_pkg.sv @@
// Shared types and constants for the vertex transform and viewport block.
package vtv_pkg;

   // Field widths fixed by the item formats
   localparam int unsigned POS_W      = 32;
   localparam int unsigned SCR_W      = 32;
   localparam int unsigned DEPTH_W    = 17;
   localparam int unsigned ROW_W      = 64;
   localparam int unsigned ENTRY_W    = 16;
   localparam int unsigned DIM_REG_W  = 13;
   localparam int unsigned CSR_IDX_W  = 3;

   // Clip arithmetic widths
   localparam int unsigned PROD_W     = ENTRY_W + POS_W;   // one matrix term
   localparam int unsigned CLIP_W     = PROD_W + 1;        // sum of four terms
   localparam int unsigned NUM_W      = CLIP_W + 1;        // c + cw
   localparam int unsigned QUO_W      = 31;                // quotient bits kept
   localparam int unsigned SPLIT_W    = 25;                // low half of numerator

   localparam int unsigned DEFAULT_MAX_SCREEN_DIM = 4096;

   // Register reset values
   localparam logic [ROW_W-1:0] ROW0_RST = 64'h0000_0000_0000_1000;
   localparam logic [ROW_W-1:0] ROW1_RST = 64'h0000_0000_1000_0000;
   localparam logic [ROW_W-1:0] ROW2_RST = 64'h0000_1000_0000_0000;
   localparam logic [ROW_W-1:0] ROW3_RST = 64'h1000_0000_0000_0000;
   localparam logic [DIM_REG_W-1:0] WIDTH_RST  = 13'd640;
   localparam logic [DIM_REG_W-1:0] HEIGHT_RST = 13'd480;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MVP_ROW0      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MVP_ROW1      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MVP_ROW2      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MVP_ROW3      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = 3'd5;

   localparam logic [DEPTH_W-1:0] DEPTH_ONE = 17'h10000;

   typedef struct packed {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
   } req_type;

   typedef struct packed {
      logic signed [SCR_W-1:0] screen_x;
      logic signed [SCR_W-1:0] screen_y;
      logic [DEPTH_W-1:0]      depth_out;
      logic                    w_zero;
   } rsp_type;

endpackage

@@ rtl/vertex_transform_viewport.sv @@
// Pipelined perspective vertex transform with viewport mapping.
//
// Input: start/busy command channel carrying req_data (Q16.16 x, y, z).
// An item is taken at each edge where start is high and busy is low; busy
// is high only while reset is asserted, so one vertex may enter per cycle.
// Output: rsp_valid strobes for one cycle with rsp_data (screen x/y in
// Q16.16, depth in Q1.16, w_zero flag). The receiver cannot stall.
// Pipeline steps, in order: the 16 matrix multipliers, the row sums, the
// split numerator-by-scale product, the restoring divider (one quotient
// bit per stage, three lanes sharing the clip-w denominator) and one output
// register. Throughput is one item per cycle while reset is low.
// Configuration: csr_valid/csr_ready write port, always ready; registers
// must only be written while no item is in flight.
// Reset: synchronous; clears the pipeline valid bits and restores the
// identity matrix and a 640x480 viewport.
module vertex_transform_viewport #(
   parameter int unsigned MAX_SCREEN_DIM = vtv_pkg::DEFAULT_MAX_SCREEN_DIM
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  vtv_pkg::req_type               req_data,
   output logic                           rsp_valid,
   output vtv_pkg::rsp_type               rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [vtv_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [vtv_pkg::ROW_W-1:0]      csr_wdata
);
   import vtv_pkg::*;

   localparam int unsigned DIM_W   = $clog2(MAX_SCREEN_DIM + 1);
   localparam int unsigned SCALE_W = DIM_W + 15;
   localparam int unsigned MAG_W   = NUM_W;
   localparam int unsigned DEN_W   = CLIP_W;
   localparam int unsigned HI_W    = MAG_W - SPLIT_W;
   localparam int unsigned N_W     = MAG_W + SCALE_W;
   localparam int unsigned DV_W    = DEN_W + QUO_W;
   localparam int unsigned RW      = (N_W > DV_W) ? N_W : DV_W;
   localparam int unsigned LAT     = 36;

   // Configuration registers
   logic [ROW_W-1:0]     row_ff [4];
   logic [DIM_REG_W-1:0] width_ff, height_ff;

   assign csr_ready = 1'b1;
   assign busy      = reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff[0] <= ROW0_RST;
         row_ff[1] <= ROW1_RST;
         row_ff[2] <= ROW2_RST;
         row_ff[3] <= ROW3_RST;
         width_ff  <= WIDTH_RST;
         height_ff <= HEIGHT_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MVP_ROW0:      row_ff[0] <= csr_wdata;
            CSR_MVP_ROW1:      row_ff[1] <= csr_wdata;
            CSR_MVP_ROW2:      row_ff[2] <= csr_wdata;
            CSR_MVP_ROW3:      row_ff[3] <= csr_wdata;
            CSR_SCREEN_WIDTH:  width_ff  <= csr_wdata[DIM_REG_W-1:0];
            CSR_SCREEN_HEIGHT: height_ff <= csr_wdata[DIM_REG_W-1:0];
            default: ;
         endcase
      end
   end

   // Viewport scales, dimension clamped to the maximum
   logic [SCALE_W-1:0] scale [3];
   logic [DIM_W-1:0]   wdim, hdim;

   always_comb begin
      wdim = (32'(width_ff) > 32'(MAX_SCREEN_DIM)) ? DIM_W'(MAX_SCREEN_DIM)
                                                   : DIM_W'(width_ff);
      hdim = (32'(height_ff) > 32'(MAX_SCREEN_DIM)) ? DIM_W'(MAX_SCREEN_DIM)
                                                    : DIM_W'(height_ff);
      scale[0] = SCALE_W'(wdim) << 15;
      scale[1] = SCALE_W'(hdim) << 15;
      scale[2] = SCALE_W'(32768);
   end

   // Stage 1: matrix terms
   logic                     v1_ff;
   logic signed [PROD_W-1:0] prod_ff [4][4];
   logic signed [POS_W-1:0]  pvec [4];

   assign pvec[0] = req_data.pos_x;
   assign pvec[1] = req_data.pos_y;
   assign pvec[2] = req_data.pos_z;
   assign pvec[3] = POS_W'(65536);

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else       v1_ff <= start && !busy;
      for (int r = 0; r < 4; r++) begin
         for (int j = 0; j < 4; j++) begin
            prod_ff[r][j] <= PROD_W'($signed(row_ff[r][ENTRY_W*j +: ENTRY_W]) * pvec[j]);
         end
      end
   end

   // Stage 2: row sums, numerators c + cw
   logic                     v2_ff;
   logic signed [NUM_W-1:0]  num_ff [3];
   logic signed [CLIP_W-1:0] cw_ff;
   logic signed [CLIP_W-1:0] clip [4];

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         clip[r] = '0;
         for (int j = 0; j < 4; j++) clip[r] = clip[r] + CLIP_W'(prod_ff[r][j]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else       v2_ff <= v1_ff;
      for (int l = 0; l < 3; l++) num_ff[l] <= NUM_W'(clip[l]) + NUM_W'(clip[3]);
      cw_ff <= clip[3];
   end

   // Stage 3: magnitudes and split numerator-by-scale products
   logic                        v3_ff;
   logic [SPLIT_W+SCALE_W-1:0]  pplo_ff [3];
   logic [HI_W+SCALE_W-1:0]     pphi_ff [3];
   logic [2:0]                  neg3_ff;
   logic [DEN_W-1:0]            den3_ff;
   logic                        wz3_ff;
   logic [MAG_W-1:0]            nmag [3];

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         nmag[l] = num_ff[l][NUM_W-1] ? MAG_W'(-num_ff[l]) : MAG_W'(num_ff[l]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else       v3_ff <= v2_ff;
      for (int l = 0; l < 3; l++) begin
         pplo_ff[l] <= (SPLIT_W+SCALE_W)'(nmag[l][SPLIT_W-1:0]) *
                       (SPLIT_W+SCALE_W)'(scale[l]);
         pphi_ff[l] <= (HI_W+SCALE_W)'(nmag[l][MAG_W-1:SPLIT_W]) *
                       (HI_W+SCALE_W)'(scale[l]);
         neg3_ff[l] <= num_ff[l][NUM_W-1] ^ cw_ff[CLIP_W-1];
      end
      den3_ff <= cw_ff[CLIP_W-1] ? DEN_W'(-cw_ff) : DEN_W'(cw_ff);
      wz3_ff  <= (cw_ff == '0);
   end

   // Divider pipeline: stage 0 holds the full numerator, stage s settles
   // quotient bit QUO_W-s
   logic              dv_ff  [QUO_W+1];
   logic              wz_ff  [QUO_W+1];
   logic [DEN_W-1:0]  den_ff [QUO_W+1];
   logic [RW-1:0]     rem_ff [3][QUO_W+1];
   logic [QUO_W-1:0]  q_ff   [3][QUO_W+1];
   logic              neg_ff [3][QUO_W+1];
   logic              sat_ff [3][QUO_W+1];

   logic [RW-1:0]     nfull  [3];
   logic [RW-1:0]     rem_in [3][QUO_W];
   logic [QUO_W-1:0]  q_in   [3][QUO_W];
   logic [RW-1:0]     dsh;

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         nfull[l] = (RW'(pphi_ff[l]) << SPLIT_W) + RW'(pplo_ff[l]);
      end
      for (int l = 0; l < 3; l++) begin
         for (int s = 0; s < QUO_W; s++) begin
            dsh = RW'(den_ff[s]) << (QUO_W - 1 - s);
            if (rem_ff[l][s] >= dsh) begin
               rem_in[l][s] = rem_ff[l][s] - dsh;
               q_in[l][s]   = q_ff[l][s] | (QUO_W'(1) << (QUO_W - 1 - s));
            end else begin
               rem_in[l][s] = rem_ff[l][s];
               q_in[l][s]   = q_ff[l][s];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= QUO_W; s++) dv_ff[s] <= 1'b0;
      end else begin
         dv_ff[0] <= v3_ff;
         for (int s = 0; s < QUO_W; s++) dv_ff[s+1] <= dv_ff[s];
      end
      den_ff[0] <= den3_ff;
      wz_ff[0]  <= wz3_ff;
      for (int l = 0; l < 3; l++) begin
         rem_ff[l][0] <= nfull[l];
         q_ff[l][0]   <= '0;
         neg_ff[l][0] <= neg3_ff[l];
         sat_ff[l][0] <= nfull[l] >= (RW'(den3_ff) << QUO_W);
      end
      for (int s = 0; s < QUO_W; s++) begin
         den_ff[s+1] <= den_ff[s];
         wz_ff[s+1]  <= wz_ff[s];
         for (int l = 0; l < 3; l++) begin
            rem_ff[l][s+1] <= rem_in[l][s];
            q_ff[l][s+1]   <= q_in[l][s];
            neg_ff[l][s+1] <= neg_ff[l][s];
            sat_ff[l][s+1] <= sat_ff[l][s];
         end
      end
   end

   // Output stage: sign, saturation, depth clamp
   logic                    rv_ff;
   rsp_type                 rsp_ff;
   logic signed [SCR_W-1:0] sval [3];
   logic [DEPTH_W-1:0]      dval;

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         if (sat_ff[l][QUO_W])
            sval[l] = neg_ff[l][QUO_W] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
         else if (neg_ff[l][QUO_W])
            sval[l] = -$signed(SCR_W'(q_ff[l][QUO_W]));
         else
            sval[l] = $signed(SCR_W'(q_ff[l][QUO_W]));
      end
      if (sval[2] < 0)
         dval = '0;
      else if (sval[2] > $signed(SCR_W'(DEPTH_ONE)))
         dval = DEPTH_ONE;
      else
         dval = DEPTH_W'(sval[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) rv_ff <= 1'b0;
      else       rv_ff <= dv_ff[QUO_W];
      if (wz_ff[QUO_W]) begin
         rsp_ff <= '{screen_x: '0, screen_y: '0, depth_out: '0, w_zero: 1'b1};
      end else begin
         rsp_ff <= '{screen_x: sval[0], screen_y: sval[1], depth_out: dval,
                     w_zero: 1'b0};
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   // Every accepted item comes out after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_valid)
      else $error("item did not emerge after pipeline latency");

   // Depth stays within [0, 1.0]
   a_depth_range: assert property (@(posedge clock)
      rsp_valid |-> (rsp_data.depth_out <= DEPTH_ONE))
      else $error("depth out of range");

   // Zero clip w forces zero coordinates
   a_wzero_clear: assert property (@(posedge clock)
      (rsp_valid && rsp_data.w_zero) |->
         (rsp_data.screen_x == 0 && rsp_data.screen_y == 0 && rsp_data.depth_out == 0))
      else $error("w_zero result carries nonzero fields");

   // No result strobes right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result strobe right after reset");
`endif

endmodule
